FILE: rtl/ilid_pkg.sv
package ilid_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);
  localparam int unsigned POS_W      = 7;
  localparam int unsigned CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE,
    CM_ROTATE
  } cell_mode_e;

  typedef struct packed {
    cell_mode_e            mode;
    logic [IDX_W-1:0]      pos;
    logic [IDX_W-1:0]      last_idx;
    logic [DATA_WIDTH-1:0] ins_word;
  } cell_ctrl_t;

endpackage

FILE: rtl/ilid_cell.sv
module ilid_cell (
  input  logic                           clk_i,
  input  ilid_pkg::cell_ctrl_t           ctrl_i,
  input  logic [ilid_pkg::IDX_W-1:0]     idx_i,
  input  logic [ilid_pkg::DATA_WIDTH-1:0] left_i,
  input  logic [ilid_pkg::DATA_WIDTH-1:0] right_i,
  input  logic [ilid_pkg::DATA_WIDTH-1:0] head_i,
  output logic [ilid_pkg::DATA_WIDTH-1:0] word_o
);
  import ilid_pkg::*;

  logic [DATA_WIDTH-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (ctrl_i.mode)
      CM_INSERT: begin
        if (idx_i > ctrl_i.pos) begin
          word_d = left_i;
        end else if (idx_i == ctrl_i.pos) begin
          word_d = ctrl_i.ins_word;
        end
      end
      CM_REMOVE: begin
        if (idx_i >= ctrl_i.pos) begin
          word_d = right_i;
        end
      end
      CM_ROTATE: begin
        if (idx_i == ctrl_i.last_idx) begin
          word_d = head_i;
        end else if (idx_i < ctrl_i.last_idx) begin
          word_d = right_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

FILE: rtl/indexed_list_insert_delete.sv
// Bounded ordered list of signed words held in a row of shift cells.
// Command channel: operation_i, position_i and value_i are taken at a rising
// edge with start_i high and busy_o low.
// Result channel: out_valid_o marks each result word for one cycle; the
// receiver takes it at the end of that cycle and cannot hold it off.
// Insert and remove: the cells from position_i upward shift in the same cycle;
// one result word follows in the cycle after the command, and busy_o stays
// low, so a new command can be given every cycle.
// Dump: the cells rotate the first count entries toward cell 0, one per
// cycle, emitting the head each cycle. One result word comes per entry
// (a single one for an empty list), the first in the cycle after the command;
// busy_o is high until the final word is out. After count rotations the list
// is back in its original order. last_o marks the final word of each command.
// Reset empties the list (count zero); the cell contents are not cleared
// and are never read below an unwritten position.
module indexed_list_insert_delete (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic [1:0]            operation_i,
  input  logic [6:0]            position_i,
  input  logic signed [31:0]    value_i,
  output logic                  out_valid_o,
  output logic [1:0]            status_o,
  output logic signed [31:0]    item_value_o,
  output logic                  item_valid_o,
  output logic [6:0]            entry_count_o,
  output logic                  last_o
);
  import ilid_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   rem_q;

  logic                  accept;
  logic [CMP_W-1:0]      pos_ext, cnt_ext;
  logic                  ins_range, ins_full, rem_range;
  cell_ctrl_t            ctrl;
  logic [DATA_WIDTH-1:0] word [DEPTH];

  assign accept    = start_i && !busy_o;
  assign busy_o    = (state_q == S_DUMP);
  assign pos_ext   = CMP_W'(position_i);
  assign cnt_ext   = CMP_W'(count_q);
  assign ins_range = pos_ext > cnt_ext;
  assign ins_full  = count_q == CNT_W'(DEPTH);
  assign rem_range = pos_ext >= cnt_ext;

  always_comb begin
    ctrl.mode     = CM_HOLD;
    ctrl.pos      = IDX_W'(position_i);
    ctrl.last_idx = IDX_W'(count_q - CNT_W'(1));
    ctrl.ins_word = DATA_WIDTH'($unsigned(value_i));
    if (state_q == S_DUMP) begin
      ctrl.mode = CM_ROTATE;
    end else if (accept) begin
      case (op_e'(operation_i))
        OP_INSERT: if (!ins_range && !ins_full) ctrl.mode = CM_INSERT;
        OP_REMOVE: if (!rem_range) ctrl.mode = CM_REMOVE;
        OP_DUMP:   if (count_q != '0) ctrl.mode = CM_ROTATE;
        default:   ctrl.mode = CM_HOLD;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [DATA_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = word[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid_r
      assign right = word[g+1];
    end
    ilid_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .idx_i   (IDX_W'(g)),
      .left_i  (left),
      .right_i (right),
      .head_i  (word[0]),
      .word_o  (word[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      rem_q         <= '0;
      out_valid_o   <= 1'b0;
      status_o      <= ST_OK;
      item_value_o  <= '0;
      item_valid_o  <= 1'b0;
      entry_count_o <= '0;
      last_o        <= 1'b0;
    end else begin
      out_valid_o  <= 1'b0;
      status_o     <= ST_OK;
      item_value_o <= '0;
      item_valid_o <= 1'b0;
      last_o       <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_valid_o   <= 1'b1;
            entry_count_o <= 7'(count_q);
            case (op_e'(operation_i))
              OP_INSERT: begin
                if (ins_range) begin
                  status_o <= ST_RANGE;
                end else if (ins_full) begin
                  status_o <= ST_FULL;
                end else begin
                  count_q       <= count_q + CNT_W'(1);
                  entry_count_o <= 7'(count_q + CNT_W'(1));
                end
              end
              OP_REMOVE: begin
                if (rem_range) begin
                  status_o <= ST_RANGE;
                end else begin
                  count_q       <= count_q - CNT_W'(1);
                  entry_count_o <= 7'(count_q - CNT_W'(1));
                end
              end
              OP_DUMP: begin
                if (count_q != '0) begin
                  item_value_o <= 32'(word[0]);
                  item_valid_o <= 1'b1;
                  last_o       <= (count_q == CNT_W'(1));
                  rem_q        <= count_q - CNT_W'(1);
                  if (count_q != CNT_W'(1)) state_q <= S_DUMP;
                end
              end
              default: ;
            endcase
          end
        end
        S_DUMP: begin
          out_valid_o   <= 1'b1;
          entry_count_o <= 7'(count_q);
          item_value_o  <= 32'(word[0]);
          item_valid_o  <= 1'b1;
          last_o        <= (rem_q == CNT_W'(1));
          rem_q         <= rem_q - CNT_W'(1);
          if (rem_q == CNT_W'(1)) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("count above depth");

  a_dump_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> (rem_q != '0) && (rem_q < count_q)) else $error("dump counter bad");

  a_cmd_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o) else $error("command without result");

  a_dump_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o) else $error("dump stream broken");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> !busy_o) else $error("busy after last word");

endmodule
